// File: src/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define RRTST_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on every edge, reset included
`define RRTST_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: src/rrtst_pkg.sv
package rrtst_pkg;

    localparam int TASK_SLOTS  = 16;
    localparam int SLOT_W      = $clog2(TASK_SLOTS);
    localparam int FRAME_WORDS = 16;
    localparam int WORD_W      = $clog2(FRAME_WORDS);
    localparam int DATA_W      = 32;
    localparam int STACK_W     = 21;
    localparam int OPCODE_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_OUT_W  = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [DATA_W-1:0] RESET_RAM_BASE    = 32'h2000_0000;
    localparam logic [DATA_W-1:0] RESET_RAM_BYTES   = 32'h0001_0000;
    localparam logic [STACK_W-1:0] RESET_STACK_BYTES = 21'd1024;

    // frame word size in bytes
    localparam logic [DATA_W-1:0] WORD_BYTES = 32'd4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_REGISTER = 2'd0,
        OP_TICK     = 2'd1,
        OP_START    = 2'd2
    } rrtst_opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_FRAME_WORD   = 2'd0,
        STS_TABLE_FULL   = 2'd1,
        STS_NEW_SP       = 2'd2,
        STS_TICK_IGNORED = 2'd3
    } rrtst_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAM_BASE    = 2'd0,
        CFG_RAM_BYTES   = 2'd1,
        CFG_STACK_BYTES = 2'd2
    } rrtst_cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FRAME,
        S_RESP_PTR,
        S_RESP_MISC
    } rrtst_state_t;

    // initial exception frame in push order, pc word replaced by the entry
    localparam logic [DATA_W-1:0] FRAME_FIXED [FRAME_WORDS] = '{
        32'h0100_0000, 32'h0000_0000, 32'hFFFF_FFFD, 32'h1212_1212,
        32'h0303_0303, 32'h0202_0202, 32'h0101_0101, 32'h0000_0000,
        32'h1111_1111, 32'h1010_1010, 32'h0909_0909, 32'h0808_0808,
        32'h0707_0707, 32'h0606_0606, 32'h0505_0505, 32'h0404_0404
    };

    localparam logic [WORD_W-1:0] PC_WORD = WORD_W'(1);

    function automatic logic [DATA_W-1:0] frame_word(
        input logic [WORD_W-1:0] k,
        input logic [DATA_W-1:0] entry
    );
        logic [DATA_W-1:0] w;
        w = FRAME_FIXED[k];
        if (k == PC_WORD)
            w = entry;
        return w;
    endfunction

endpackage

// File: src/rrtst_req_if.sv
interface rrtst_req_if
    import rrtst_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [DATA_W-1:0]   entry_address;
    logic [DATA_W-1:0]   saved_stack_pointer;

    modport source (output valid, output opcode, output entry_address,
                    output saved_stack_pointer, input ready);
    modport sink   (input valid, input opcode, input entry_address,
                    input saved_stack_pointer, output ready);
endinterface

// File: src/rrtst_rsp_if.sv
interface rrtst_rsp_if
    import rrtst_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [DATA_W-1:0]     word_address;
    logic [DATA_W-1:0]     word_value;
    logic [DATA_W-1:0]     next_stack_pointer;
    logic                  last;

    modport source (output valid, output status, output slot_index,
                    output word_address, output word_value,
                    output next_stack_pointer, output last, input ready);
    modport sink   (input valid, input status, input slot_index,
                    input word_address, input word_value,
                    input next_stack_pointer, input last, output ready);
endinterface

// File: src/round_robin_task_stack_table_top.sv
// round-robin task stack table: keeps one saved stack pointer per task slot
// (zero means empty) in a single-port-write, registered-read ram, with an
// occupancy flag per slot in flip-flops so the table reads as empty straight
// after reset without any clearing pass. a register transaction scans the
// occupancy flags one slot per cycle for the first empty slot, then emits
// the sixteen initial frame words one per cycle while the output register
// is free, and stores top - 64. tick and start read the next slot from the
// ram on acceptance, tick also writing the saved pointer; in S_RESP_PTR the
// result is then taken from the ram read port, or from the saved pointer when
// the tick wraps onto the slot just written. ignored ticks answer through
// S_RESP_MISC and unknown opcodes return to idle with no result. input is
// taken only when the block is idle, but a result waiting in the output
// register does not hold off the next input transaction. configuration
// writes are expected only while the block is idle.
module round_robin_task_stack_table_top
    import rrtst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    rrtst_req_if.sink            req,
    rrtst_rsp_if.source          rsp
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(FRAME_WORDS - 1);

    // fsm and control state
    rrtst_state_t          state_reg, state_next;
    logic                  running_reg, running_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [TASK_SLOTS-1:0] occ_reg, occ_next;

    // configuration
    logic [DATA_W-1:0]  ram_base_reg, ram_base_next;
    logic [DATA_W-1:0]  ram_bytes_reg, ram_bytes_next;
    logic [STACK_W-1:0] stack_bytes_reg, stack_bytes_next;

    // working registers of the current transaction
    logic [SLOT_W-1:0] scan_reg, scan_next;
    logic [DATA_W-1:0] off_reg, off_next;
    logic [DATA_W-1:0] top_base_reg, top_base_next;
    logic [DATA_W-1:0] addr_reg, addr_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [DATA_W-1:0] entry_reg, entry_next;
    logic [DATA_W-1:0] saved_reg, saved_next;
    logic              fwd_reg, fwd_next;
    rrtst_status_t     code_reg, code_next;

    // output register
    logic                  rsp_valid_reg, rsp_valid_next;
    rrtst_status_t         status_reg, status_next;
    logic [SLOT_OUT_W-1:0] slot_reg, slot_next;
    logic [DATA_W-1:0]     waddr_out_reg, waddr_out_next;
    logic [DATA_W-1:0]     wval_reg, wval_next;
    logic [DATA_W-1:0]     nsp_reg, nsp_next;
    logic                  last_reg, last_next;

    // ram port
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              req_fire;
    logic              out_free;
    logic [SLOT_W-1:0] cur_inc;
    logic [SLOT_W-1:0] tick_slot;

    rrtst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TASK_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    // output register may take a new result when empty or being drained
    assign out_free = !rsp_valid_reg || rsp.ready;

    // round-robin successor: wraps after the last slot or at an empty slot
    assign cur_inc   = cur_reg + SLOT_W'(1);
    assign tick_slot = ((cur_reg == LAST_SLOT) || !occ_reg[cur_inc]) ? '0 : cur_inc;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (rrtst_opcode_t'(req.opcode))
                        OP_REGISTER: state_next = S_SCAN;
                        OP_TICK:     state_next = running_reg ? S_RESP_PTR : S_RESP_MISC;
                        OP_START:    state_next = S_RESP_PTR;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!occ_reg[scan_reg])
                    state_next = S_FRAME;
                else if (scan_reg == LAST_SLOT)
                    state_next = S_RESP_MISC;
            end
            S_FRAME:
            begin
                if (out_free && (word_reg == LAST_WORD))
                    state_next = S_IDLE;
            end
            S_RESP_PTR,
            S_RESP_MISC:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        running_next     = running_reg;
        cur_next         = cur_reg;
        occ_next         = occ_reg;
        ram_base_next    = ram_base_reg;
        ram_bytes_next   = ram_bytes_reg;
        stack_bytes_next = stack_bytes_reg;
        scan_next        = scan_reg;
        off_next         = off_reg;
        top_base_next    = top_base_reg;
        addr_next        = addr_reg;
        word_next        = word_reg;
        entry_next       = entry_reg;
        saved_next       = saved_reg;
        fwd_next         = fwd_reg;
        code_next        = code_reg;

        status_next    = status_reg;
        slot_next      = slot_reg;
        waddr_out_next = waddr_out_reg;
        wval_next      = wval_reg;
        nsp_next       = nsp_reg;
        last_next      = last_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        if (cfg_we)
        begin
            case (rrtst_cfg_idx_t'(cfg_index))
                CFG_RAM_BASE:    ram_base_next    = cfg_wdata;
                CFG_RAM_BYTES:   ram_bytes_next   = cfg_wdata;
                CFG_STACK_BYTES: stack_bytes_next = cfg_wdata[STACK_W-1:0];
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    entry_next = req.entry_address;
                    saved_next = req.saved_stack_pointer;
                    case (rrtst_opcode_t'(req.opcode))
                        OP_REGISTER:
                        begin
                            scan_next     = '0;
                            off_next      = DATA_W'(stack_bytes_reg);
                            // top of slot s is this minus (s+1)*stack, less one word
                            top_base_next = ram_base_reg + ram_bytes_reg - WORD_BYTES;
                        end
                        OP_TICK:
                        begin
                            if (running_reg)
                            begin
                                ram_we            = 1'b1;
                                ram_waddr         = cur_reg;
                                ram_wdata         = req.saved_stack_pointer;
                                occ_next[cur_reg] = (req.saved_stack_pointer != '0);
                                cur_next          = tick_slot;
                                ram_re            = 1'b1;
                                ram_raddr         = tick_slot;
                                // wrapped back onto the slot just written
                                fwd_next          = (tick_slot == cur_reg);
                            end
                            else
                            begin
                                code_next = STS_TICK_IGNORED;
                            end
                        end
                        OP_START:
                        begin
                            cur_next     = '0;
                            running_next = 1'b1;
                            ram_re       = 1'b1;
                            ram_raddr    = '0;
                            fwd_next     = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!occ_reg[scan_reg])
                begin
                    addr_next = top_base_reg - off_reg;
                    word_next = '0;
                end
                else if (scan_reg == LAST_SLOT)
                begin
                    code_next = STS_TABLE_FULL;
                end
                else
                begin
                    scan_next = scan_reg + SLOT_W'(1);
                    off_next  = off_reg + DATA_W'(stack_bytes_reg);
                end
            end
            S_FRAME:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = STS_FRAME_WORD;
                    slot_next      = SLOT_OUT_W'(scan_reg);
                    waddr_out_next = addr_reg;
                    wval_next      = frame_word(word_reg, entry_reg);
                    nsp_next       = '0;
                    last_next      = (word_reg == LAST_WORD);
                    addr_next      = addr_reg - WORD_BYTES;
                    word_next      = word_reg + WORD_W'(1);
                    if (word_reg == LAST_WORD)
                    begin
                        // last word sits at top - 64, the saved pointer
                        ram_we             = 1'b1;
                        ram_waddr          = scan_reg;
                        ram_wdata          = addr_reg;
                        occ_next[scan_reg] = (addr_reg != '0);
                    end
                end
            end
            S_RESP_PTR:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = STS_NEW_SP;
                    slot_next      = SLOT_OUT_W'(cur_reg);
                    waddr_out_next = '0;
                    wval_next      = '0;
                    if (fwd_reg)
                        nsp_next = saved_reg;
                    else
                        nsp_next = occ_reg[cur_reg] ? ram_rdata : '0;
                    last_next      = 1'b1;
                end
            end
            S_RESP_MISC:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = code_reg;
                    slot_next      = '0;
                    waddr_out_next = '0;
                    wval_next      = '0;
                    nsp_next       = '0;
                    last_next      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            running_reg     <= 1'b0;
            cur_reg         <= '0;
            occ_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
            ram_base_reg    <= RESET_RAM_BASE;
            ram_bytes_reg   <= RESET_RAM_BYTES;
            stack_bytes_reg <= RESET_STACK_BYTES;
        end
        else
        begin
            state_reg       <= state_next;
            running_reg     <= running_next;
            cur_reg         <= cur_next;
            occ_reg         <= occ_next;
            rsp_valid_reg   <= rsp_valid_next;
            ram_base_reg    <= ram_base_next;
            ram_bytes_reg   <= ram_bytes_next;
            stack_bytes_reg <= stack_bytes_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        scan_reg      <= scan_next;
        off_reg       <= off_next;
        top_base_reg  <= top_base_next;
        addr_reg      <= addr_next;
        word_reg      <= word_next;
        entry_reg     <= entry_next;
        saved_reg     <= saved_next;
        fwd_reg       <= fwd_next;
        code_reg      <= code_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        waddr_out_reg <= waddr_out_next;
        wval_reg      <= wval_next;
        nsp_reg       <= nsp_next;
        last_reg      <= last_next;
    end

    assign rsp.valid              = rsp_valid_reg;
    assign rsp.status             = status_reg;
    assign rsp.slot_index         = slot_reg;
    assign rsp.word_address       = waddr_out_reg;
    assign rsp.word_value         = wval_reg;
    assign rsp.next_stack_pointer = nsp_reg;
    assign rsp.last               = last_reg;

endmodule

// File: src/rrtst_ram.sv
module rrtst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/rrtst_checker.sv
`include "assert_macros.svh"

module rrtst_checker
    import rrtst_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [STATUS_W-1:0]   rsp_status,
    input logic [SLOT_OUT_W-1:0] rsp_slot_index,
    input logic [DATA_W-1:0]     rsp_word_address,
    input logic [DATA_W-1:0]     rsp_word_value,
    input logic [DATA_W-1:0]     rsp_next_stack_pointer,
    input logic                  rsp_last
);

    logic rsp_stalled;
    logic rsp_frame;
    logic rsp_single;
    logic rsp_no_slot;
    logic sp_zero;
    logic unused_zero;

    assign rsp_stalled = rsp_valid && !rsp_ready;
    assign rsp_frame   = rsp_valid && (rsp_status == STS_FRAME_WORD);
    assign rsp_single  = rsp_valid && (rsp_status != STS_FRAME_WORD);
    assign rsp_no_slot = rsp_valid && ((rsp_status == STS_TABLE_FULL)
                                       || (rsp_status == STS_TICK_IGNORED));
    assign sp_zero     = (rsp_next_stack_pointer == '0);
    assign unused_zero = (rsp_slot_index == '0) && (rsp_word_address == '0)
                         && (rsp_word_value == '0);

    `RRTST_ASSERT_ALWAYS(a_no_valid_in_reset, clk, !rst_n |-> !rsp_valid, "result during reset")

    `RRTST_ASSERT(a_valid_held, clk, rst_n, rsp_stalled |=> rsp_valid, "result dropped")

    `RRTST_ASSERT(a_single_results_last, clk, rst_n, rsp_single |-> rsp_last, "result not last")

    `RRTST_ASSERT(a_frame_no_sp, clk, rst_n, rsp_frame |-> sp_zero, "pointer on frame word")

    `RRTST_ASSERT(a_empty_fields, clk, rst_n, rsp_no_slot |-> unused_zero, "unused field set")

endmodule

bind round_robin_task_stack_table_top rrtst_checker u_rrtst_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .rsp_valid              (rsp.valid),
    .rsp_ready              (rsp.ready),
    .rsp_status             (rsp.status),
    .rsp_slot_index         (rsp.slot_index),
    .rsp_word_address       (rsp.word_address),
    .rsp_word_value         (rsp.word_value),
    .rsp_next_stack_pointer (rsp.next_stack_pointer),
    .rsp_last               (rsp.last)
);
